// ===== rtl/core/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int unsigned VALUE_W = 21;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned REM_W   = 2;

  localparam logic [7:0] MARK_LO = 8'h81;
  localparam logic [7:0] MARK_HI = 8'h85;

  typedef enum logic [1:0] {
    KIND_CODE = 2'd0,
    KIND_MARK = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Sequence state carried from one byte to the next.
  typedef struct packed {
    logic [REM_W-1:0]   bytes_remaining;
    logic [VALUE_W-1:0] partial_value;
    logic [LEN_W-1:0]   sequence_length;
  } seq_state_t;

  // One result as produced by the decode step.
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   byte_len;
  } result_t;

endpackage

// ===== rtl/core/utf8d_step.sv =====
// Combinational decode of one byte against the current sequence state.
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic [7:0] data_byte,
  input  seq_state_t state_cur,
  output seq_state_t state_nxt,
  output result_t    result
);

  logic [VALUE_W-1:0] shifted;
  logic [REM_W-1:0]   rem_dec;

  assign shifted = {state_cur.partial_value[VALUE_W-7:0], data_byte[5:0]};
  assign rem_dec = state_cur.bytes_remaining - REM_W'(1);

  always_comb begin
    state_nxt       = state_cur;
    result.valid    = 1'b0;
    result.kind     = KIND_CODE;
    result.value    = '0;
    result.byte_len = LEN_W'(1);

    if (state_cur.bytes_remaining != '0) begin
      // Inside a sequence every byte counts as a continuation.
      state_nxt.bytes_remaining = rem_dec;
      if (rem_dec != '0) begin
        state_nxt.partial_value = shifted;
      end else begin
        result.valid              = 1'b1;
        result.kind               = KIND_CODE;
        result.value              = shifted;
        result.byte_len           = state_cur.sequence_length;
        state_nxt.partial_value   = '0;
        state_nxt.sequence_length = '0;
      end
    end else if (data_byte >= MARK_LO && data_byte <= MARK_HI) begin
      result.valid = 1'b1;
      result.kind  = KIND_MARK;
      result.value = VALUE_W'(data_byte);
    end else if (data_byte[7:4] == 4'hF) begin
      state_nxt.partial_value   = VALUE_W'(data_byte[2:0]);
      state_nxt.sequence_length = LEN_W'(4);
      state_nxt.bytes_remaining = REM_W'(3);
    end else if (data_byte[7:4] == 4'hE) begin
      state_nxt.partial_value   = VALUE_W'(data_byte[3:0]);
      state_nxt.sequence_length = LEN_W'(3);
      state_nxt.bytes_remaining = REM_W'(2);
    end else if (data_byte[7:5] == 3'b110) begin
      state_nxt.partial_value   = VALUE_W'(data_byte[4:0]);
      state_nxt.sequence_length = LEN_W'(2);
      state_nxt.bytes_remaining = REM_W'(1);
    end else if (!data_byte[7]) begin
      result.valid = 1'b1;
      result.kind  = KIND_CODE;
      result.value = VALUE_W'(data_byte[6:0]);
    end else begin
      result.valid = 1'b1;
      result.kind  = KIND_ERR;
    end
  end

endmodule

// ===== rtl/core/utf8_stream_decoder_with_markers.sv =====
// Top level of the UTF-8 stream decoder with framing markers.
//
// One raw byte enters per item on the in_ channel (valid/ready); decoded
// results leave on the out_ channel (valid/ready) as kind, value and byte_len.
// A complete code point, a framing marker (bytes 0x81 to 0x85 at lead
// position) or a malformed lead each give one result item; lead and
// continuation bytes that do not finish a sequence give none.
// An accepted byte is held in an input register and decoded combinationally
// against the sequence state; its result is written to the output register
// once that register is free and is offered from there. The block sustains
// one byte per cycle while the receiver does not stall; that figure is set by
// the single decode pass between the input and output registers.
// When the receiver stalls, the output register holds its result and a byte
// that produces no result still moves on; a byte that would produce a result
// waits in the input register, and in_ready falls only once that register is
// occupied and cannot drain. Reset empties both registers and returns the
// sequence state to idle, so the next byte is read as a lead byte.
module utf8_stream_decoder_with_markers
  import utf8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [VALUE_W-1:0] out_value,
  output logic [LEN_W-1:0]   out_byte_len
);

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // Sequence state and output register.
  seq_state_t         state_r;
  seq_state_t         state_nxt;
  result_t            result;
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [LEN_W-1:0]   out_len_r;

  logic out_free;
  logic advance;

  utf8d_step u_step (
    .data_byte (in_byte_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  // The held byte is consumed when it needs no output slot or one is free.
  assign advance  = in_valid_r && (!result.valid || out_free);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && result.valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
    if (advance && result.valid) begin
      out_kind_r  <= result.kind;
      out_value_r <= result.value;
      out_len_r   <= result.byte_len;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_value    = out_value_r;
  assign out_byte_len = out_len_r;

  // An open sequence always has more total bytes than bytes still to come.
  a_open_len : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_remaining != '0) |->
      ({1'b0, state_r.bytes_remaining} < state_r.sequence_length))
    else $error("sequence length inconsistent with bytes remaining");

  // When idle the stored sequence length is cleared.
  a_idle_len : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.bytes_remaining == '0) |-> (state_r.sequence_length == '0))
    else $error("stale sequence length while idle");

  // A new result only appears after a byte was held in the input register.
  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result produced without an input byte");

  // Markers are single bytes within the marker range.
  a_marker : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_MARK) |->
      (out_len_r == LEN_W'(1) && out_value_r >= VALUE_W'(MARK_LO) &&
       out_value_r <= VALUE_W'(MARK_HI)))
    else $error("malformed marker result");

  // Errors carry a zero value and consume one byte.
  a_error : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ERR) |->
      (out_len_r == LEN_W'(1) && out_value_r == '0))
    else $error("malformed error result");

endmodule
